// ===== sv/assert_macros.svh =====
// Assertion macros shared by the coast classifier RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define CAC_ASSERT(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("%m: check failed");

// Check that a trigger is followed by a consequence in the next cycle.
`define CAC_ASSERT_NEXT(lbl, clk, rst, trig, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
      else $error("%m: check failed");

`endif

// ===== sv/cac_pkg.sv =====
// Shared constants and types of the coast autotile classifier.
package cac_pkg;

   localparam int MAX_WIDTH  = 64;
   localparam int MAX_HEIGHT = 64;

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int OROW_W  = $clog2(MAX_HEIGHT);
   localparam int ROW_W   = $clog2(MAX_HEIGHT + 2);
   localparam int DIM_W   = 7;
   localparam int PIECE_W = 3;
   localparam int ADDR_W  = 3;
   localparam int DATA_W  = 32;
   localparam int LINE_W  = 2;
   localparam int WIN_W   = 9;

   localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(35);
   localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(20);
   localparam logic [DIM_W-1:0] WIDTH_MAX    = DIM_W'(MAX_WIDTH);
   localparam logic [DIM_W-1:0] HEIGHT_MAX   = DIM_W'(MAX_HEIGHT);

   localparam logic OP_TILE  = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   // register index, taken from paddr[2]
   localparam logic REG_MAP_WIDTH  = 1'b0;
   localparam logic REG_MAP_HEIGHT = 1'b1;

   localparam logic [PIECE_W-1:0] PIECE_NONE  = 3'd0;
   localparam logic [PIECE_W-1:0] PIECE_INNER = 3'd1;
   localparam logic [PIECE_W-1:0] PIECE_HORIZ = 3'd2;
   localparam logic [PIECE_W-1:0] PIECE_VERT  = 3'd3;
   localparam logic [PIECE_W-1:0] PIECE_OUTER = 3'd4;

   localparam logic [WIN_W-1:0] WINDOW_WATER = '1;

   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic             restart;
   } cfg_type;

   typedef struct packed {
      logic [COL_W-1:0] col;
      logic             store;
      logic             water;
      logic             emit;
   } item_type;

endpackage

// ===== sv/cac_csr.sv =====
// Configuration registers of the coast classifier with clamped working copies.
module cac_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [cac_pkg::ADDR_W-1:0] paddr,
   input  logic [cac_pkg::DATA_W-1:0] pwdata,
   output logic [cac_pkg::DATA_W-1:0] prdata,
   output logic                       pready,
   output cac_pkg::cfg_type           cfg
);
   import cac_pkg::*;

   logic [DIM_W-1:0] width_raw_ff;
   logic [DIM_W-1:0] height_raw_ff;
   logic [DIM_W-1:0] width_eff_ff;
   logic [DIM_W-1:0] height_eff_ff;
   logic             wr_strobe;
   logic [DIM_W-1:0] wr_value;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] vmax);
      logic [DIM_W-1:0] r;
      begin
         if (v == '0) begin
            r = DIM_W'(1);
         end else if (v > vmax) begin
            r = vmax;
         end else begin
            r = v;
         end
         return r;
      end
   endfunction

   assign wr_strobe = psel && penable && pwrite && pready;
   assign wr_value  = pwdata[DIM_W-1:0];
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_raw_ff  <= WIDTH_RESET;
         height_raw_ff <= HEIGHT_RESET;
         width_eff_ff  <= WIDTH_RESET;
         height_eff_ff <= HEIGHT_RESET;
      end else if (wr_strobe) begin
         case (paddr[2])
            REG_MAP_WIDTH: begin
               width_raw_ff <= wr_value;
               width_eff_ff <= clamp_dim(wr_value, WIDTH_MAX);
            end
            REG_MAP_HEIGHT: begin
               height_raw_ff <= wr_value;
               height_eff_ff <= clamp_dim(wr_value, HEIGHT_MAX);
            end
            default: begin
               width_raw_ff <= width_raw_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_MAP_WIDTH:  prdata = DATA_W'(width_raw_ff);
         REG_MAP_HEIGHT: prdata = DATA_W'(height_raw_ff);
         default:        prdata = '0;
      endcase
   end

   // any write restarts the frame at the same edge
   assign cfg.width   = width_eff_ff;
   assign cfg.height  = height_eff_ff;
   assign cfg.restart = wr_strobe;

endmodule

// ===== sv/cac_ram.sv =====
// Generic single-port-write, registered-read memory for the line stores.
module cac_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/cac_seq.sv =====
// Input sequencer: raster position, request filtering and result scheduling.
module cac_seq (
   input  logic              clock,
   input  logic              reset,
   input  cac_pkg::cfg_type  cfg,
   input  logic              accept,
   input  logic              op,
   input  logic              is_water,
   output logic              fed,
   output cac_pkg::item_type item
);
   import cac_pkg::*;
   `include "assert_macros.svh"

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             tile_ok;
   logic             col_wrap;
   logic             frame_last;

   assign tile_ok    = row_ff < ROW_W'(cfg.height);
   assign fed        = (op == OP_DRAIN) ? !tile_ok : tile_ok;
   assign col_wrap   = DIM_W'(col_ff) == (cfg.width - DIM_W'(1));
   assign frame_last = (row_ff == ROW_W'(cfg.height) + ROW_W'(1)) && (col_ff == '0);

   assign item.col   = col_ff;
   assign item.store = (op == OP_TILE);
   assign item.water = (op == OP_TILE) ? is_water : 1'b1;
   // a result is due once width+1 items have gone in
   assign item.emit  = (row_ff >= ROW_W'(2)) || ((row_ff == ROW_W'(1)) && (col_ff != '0));

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept && fed) begin
         if (frame_last) begin
            col_in = '0;
            row_in = '0;
         end else if (col_wrap) begin
            col_in = '0;
            row_in = row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cfg.restart) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   `CAC_ASSERT(a_col_range, clock, reset, DIM_W'(col_ff) < cfg.width)
   `CAC_ASSERT(a_row_range, clock, reset, row_ff <= ROW_W'(cfg.height) + ROW_W'(1))

endmodule

// ===== sv/cac_win.sv =====
// Window stage: line store read-modify-write, 3x3 window, corner coding, output register.
module cac_win (
   input  logic                        clock,
   input  logic                        reset,
   input  cac_pkg::cfg_type            cfg,
   input  logic                        item_load,
   input  cac_pkg::item_type           item_in,
   output logic                        busy,
   input  logic                        rsp_stall,
   output logic                        rsp_valid,
   output logic [5:0]                  rsp_tile_col,
   output logic [5:0]                  rsp_tile_row,
   output logic                        rsp_center_water,
   output logic [2:0]                  rsp_top_left_piece,
   output logic [2:0]                  rsp_top_right_piece,
   output logic [2:0]                  rsp_bottom_left_piece,
   output logic [2:0]                  rsp_bottom_right_piece,
   output logic                        rsp_frame_done
);
   import cac_pkg::*;
   `include "assert_macros.svh"

   logic              s1_valid_ff, s1_valid_in;
   item_type          s1_item_ff;
   logic [WIN_W-1:0]  window_ff;
   logic [COL_W-1:0]  out_col_ff;
   logic [OROW_W-1:0] out_row_ff;
   logic              fwd_ff;
   logic [LINE_W-1:0] fwd_data_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [COL_W-1:0]  rsp_col_ff;
   logic [OROW_W-1:0] rsp_row_ff;
   logic              rsp_center_ff;
   logic [PIECE_W-1:0] rsp_tl_ff, rsp_tr_ff, rsp_bl_ff, rsp_br_ff;
   logic              rsp_done_ff;

   logic              out_free;
   logic              s1_go;
   logic              ram_wr_en;
   logic [COL_W-1:0]  ram_wr_addr;
   logic [LINE_W-1:0] ram_wr_data;
   logic [LINE_W-1:0] ram_rd_data;
   logic [LINE_W-1:0] line_bits;
   logic [WIN_W-1:0]  wnd_new;
   logic [WIN_W-1:0]  outside;
   logic [WIN_W-1:0]  land;
   logic              at_top, at_bottom, at_left, at_right;
   logic              last_tile;
   logic [PIECE_W-1:0] tl_code, tr_code, bl_code, br_code;

   function automatic logic [PIECE_W-1:0] piece(input logic vert_land,
                                                input logic horiz_land,
                                                input logic diag_land);
      logic [PIECE_W-1:0] r;
      begin
         if (vert_land && horiz_land) begin
            r = PIECE_INNER;
         end else if (vert_land) begin
            r = PIECE_HORIZ;
         end else if (horiz_land) begin
            r = PIECE_VERT;
         end else if (diag_land) begin
            r = PIECE_OUTER;
         end else begin
            r = PIECE_NONE;
         end
         return r;
      end
   endfunction

   // line store entry: bit 1 row above, bit 0 current row
   cac_ram #(
      .DEPTH (MAX_WIDTH),
      .WIDTH (LINE_W)
   ) u_line (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (item_load),
      .rd_addr (item_in.col),
      .rd_data (ram_rd_data)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign s1_go    = s1_valid_ff && (!s1_item_ff.emit || out_free);
   assign busy     = s1_valid_ff && !s1_go;

   // take the previous write when it hit the column just read
   assign line_bits = fwd_ff ? fwd_data_ff : ram_rd_data;

   assign ram_wr_en   = s1_go && s1_item_ff.store;
   assign ram_wr_addr = s1_item_ff.col;
   assign ram_wr_data = {line_bits[0], s1_item_ff.water};

   // shift the window left by one column and bring in the fresh column
   always_comb begin
      wnd_new[0] = window_ff[1];
      wnd_new[1] = window_ff[2];
      wnd_new[2] = line_bits[1];
      wnd_new[3] = window_ff[4];
      wnd_new[4] = window_ff[5];
      wnd_new[5] = line_bits[0];
      wnd_new[6] = window_ff[7];
      wnd_new[7] = window_ff[8];
      wnd_new[8] = s1_item_ff.water;
   end

   assign at_top    = out_row_ff == '0;
   assign at_bottom = DIM_W'(out_row_ff) == (cfg.height - DIM_W'(1));
   assign at_left   = out_col_ff == '0;
   assign at_right  = DIM_W'(out_col_ff) == (cfg.width - DIM_W'(1));
   assign last_tile = at_bottom && at_right;

   // neighbors off the map count as water
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            outside[r*3+c] = (r == 0 && at_top) || (r == 2 && at_bottom) ||
                             (c == 0 && at_left) || (c == 2 && at_right);
         end
      end
   end

   assign land = ~wnd_new & ~outside;

   assign tl_code = land[4] ? PIECE_NONE : piece(land[1], land[3], land[0]);
   assign tr_code = land[4] ? PIECE_NONE : piece(land[1], land[5], land[2]);
   assign bl_code = land[4] ? PIECE_NONE : piece(land[7], land[3], land[6]);
   assign br_code = land[4] ? PIECE_NONE : piece(land[7], land[5], land[8]);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (item_load) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_go && s1_item_ff.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fwd_ff       <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (item_load) begin
            fwd_ff <= ram_wr_en && (ram_wr_addr == item_in.col);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cfg.restart) begin
         window_ff  <= WINDOW_WATER;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else if (s1_go) begin
         if (s1_item_ff.emit && last_tile) begin
            window_ff  <= WINDOW_WATER;
            out_col_ff <= '0;
            out_row_ff <= '0;
         end else begin
            window_ff <= wnd_new;
            if (s1_item_ff.emit) begin
               if (at_right) begin
                  out_col_ff <= '0;
                  out_row_ff <= out_row_ff + OROW_W'(1);
               end else begin
                  out_col_ff <= out_col_ff + COL_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_load) begin
         s1_item_ff  <= item_in;
         fwd_data_ff <= ram_wr_data;
      end
      if (s1_go && s1_item_ff.emit) begin
         rsp_col_ff    <= out_col_ff;
         rsp_row_ff    <= out_row_ff;
         rsp_center_ff <= !land[4];
         rsp_tl_ff     <= tl_code;
         rsp_tr_ff     <= tr_code;
         rsp_bl_ff     <= bl_code;
         rsp_br_ff     <= br_code;
         rsp_done_ff   <= last_tile;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_tile_col           = 6'(rsp_col_ff);
   assign rsp_tile_row           = 6'(rsp_row_ff);
   assign rsp_center_water       = rsp_center_ff;
   assign rsp_top_left_piece     = rsp_tl_ff;
   assign rsp_top_right_piece    = rsp_tr_ff;
   assign rsp_bottom_left_piece  = rsp_bl_ff;
   assign rsp_bottom_right_piece = rsp_br_ff;
   assign rsp_frame_done         = rsp_done_ff;

   `CAC_ASSERT(a_out_col_range, clock, reset, DIM_W'(out_col_ff) < cfg.width)
   `CAC_ASSERT(a_land_no_pieces, clock, reset, !(rsp_valid_ff && !rsp_center_ff) || ((rsp_tl_ff == PIECE_NONE) && (rsp_tr_ff == PIECE_NONE) && (rsp_bl_ff == PIECE_NONE) && (rsp_br_ff == PIECE_NONE)))
   `CAC_ASSERT_NEXT(a_fwd_same_col, clock, reset, item_load && ram_wr_en && (ram_wr_addr == item_in.col), fwd_ff)

endmodule

// ===== sv/coast_autotile_classifier.sv =====
// Top level of the coast autotile classifier: register port, sequencer and window stage.
// Output: a tile's result leaves width+1 requests after the tile, via the line store read
// and then the output register; drain requests push out the last row.
// Throughput: one request per cycle unless stalled; each does a line store read-modify-write.
// Reset: synchronous; map 35x20, frame at its start, window all water, line stores left as is.
module coast_autotile_classifier (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_op,
   input  logic                       req_is_water,
   // result channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [5:0]                 rsp_tile_col,
   output logic [5:0]                 rsp_tile_row,
   output logic                       rsp_center_water,
   output logic [2:0]                 rsp_top_left_piece,
   output logic [2:0]                 rsp_top_right_piece,
   output logic [2:0]                 rsp_bottom_left_piece,
   output logic [2:0]                 rsp_bottom_right_piece,
   output logic                       rsp_frame_done,
   // register port
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [cac_pkg::ADDR_W-1:0] paddr,
   input  logic [cac_pkg::DATA_W-1:0] pwdata,
   output logic [cac_pkg::DATA_W-1:0] prdata,
   output logic                       pready
);
   import cac_pkg::*;

   cfg_type  cfg;
   item_type item;
   logic     accept;
   logic     fed;
   logic     busy;

   // Map size registers; a write restarts the frame.
   cac_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Hold requests only while the window stage holds a request it cannot retire,
   // i.e. its result waits behind a stalled output register.
   assign req_stall = busy;
   assign accept    = req_valid && !busy;

   // Track raster position; drop stray tiles after the last one and early drains.
   cac_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .accept   (accept),
      .op       (req_op),
      .is_water (req_is_water),
      .fed      (fed),
      .item     (item)
   );

   // Read the line store on accept, update window and store from the registered request,
   // then classify the window center and register the result.
   cac_win u_win (
      .clock                  (clock),
      .reset                  (reset),
      .cfg                    (cfg),
      .item_load              (accept && fed),
      .item_in                (item),
      .busy                   (busy),
      .rsp_stall              (rsp_stall),
      .rsp_valid              (rsp_valid),
      .rsp_tile_col           (rsp_tile_col),
      .rsp_tile_row           (rsp_tile_row),
      .rsp_center_water       (rsp_center_water),
      .rsp_top_left_piece     (rsp_top_left_piece),
      .rsp_top_right_piece    (rsp_top_right_piece),
      .rsp_bottom_left_piece  (rsp_bottom_left_piece),
      .rsp_bottom_right_piece (rsp_bottom_right_piece),
      .rsp_frame_done         (rsp_frame_done)
   );

endmodule
